>>> hdl/dbc_pkg.sv
package dbc_pkg;

  localparam int CHANNELS    = 64;
  localparam int IDX_W       = $clog2(CHANNELS);
  localparam int COUNT_BITS  = 8;
  localparam int CH_W        = 6;
  localparam int ACT_W       = 7;
  localparam int FIELD_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_SETUP  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] thr;
    logic [COUNT_BITS-1:0] cnt;
    logic                  cand;
    logic                  stab;
    logic                  ntf;
  } ent_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            asserted;
  } evt_t;

  typedef struct packed {
    logic              room;
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

>>> hdl/dbc_front.sv
module dbc_front import dbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               func,
  input  logic [CH_W-1:0]    channel,
  input  logic               level,
  input  logic [FIELD_W-1:0] threshold,
  input  logic               start_level,
  input  logic               start_stable,
  input  logic [FIELD_W-1:0] start_count,
  input  logic               notify_enable,
  input  logic [ACT_W-1:0]   active_channels,
  output logic               push,
  output evt_t               push_evt,
  output logic               s1_setup
);

  ent_t                  mem [CHANNELS];
  logic [CHANNELS-1:0]   vld;

  logic                  s1_valid;
  logic                  s1_func;
  logic [CH_W-1:0]       s1_ch;
  logic                  s1_lvl;
  logic                  s1_in_range;
  ent_t                  s1_load;
  ent_t                  rd_data;
  logic                  rd_vld;

  logic                  fwd_valid;
  logic [CH_W-1:0]       fwd_ch;
  ent_t                  fwd_data;

  ent_t                  cur;
  ent_t                  upd;
  logic                  wr_en;
  logic                  active;
  logic [COUNT_BITS:0]   cnt_inc;
  logic                  ev;

  // current word of the channel, with forwarding of the write made at the read edge
  always_comb begin
    if (fwd_valid && fwd_ch == s1_ch) begin
      cur = fwd_data;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    upd     = cur;
    ev      = 1'b0;
    active  = {1'b0, s1_ch} < active_channels;
    cnt_inc = {1'b0, cur.cnt} + (COUNT_BITS + 1)'(1);
    wr_en   = 1'b0;
    if (s1_valid && s1_in_range) begin
      if (s1_func == FUNC_SETUP) begin
        upd   = s1_load;
        wr_en = 1'b1;
      end else if (active) begin
        wr_en = 1'b1;
        if (s1_lvl != cur.cand) begin
          upd.cnt  = '0;
          upd.cand = s1_lvl;
        end else if (cnt_inc < {1'b0, cur.thr}) begin
          upd.cnt = cnt_inc[COUNT_BITS-1:0];
        end else begin
          upd.cnt = cur.thr;
          if (cur.cand != cur.stab) begin
            upd.stab = s1_lvl;
            ev       = cur.ntf;
          end
        end
      end
    end
  end

  assign push              = ev;
  assign push_evt.ch       = s1_ch;
  assign push_evt.asserted = ~s1_lvl;
  assign s1_setup          = s1_valid && (s1_func == FUNC_SETUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      vld       <= '0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= wr_en;
      if (wr_en) begin
        vld[IDX_W'(s1_ch)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_ch   <= s1_ch;
    fwd_data <= upd;
    if (accept) begin
      s1_func      <= func;
      s1_ch        <= channel;
      s1_lvl       <= level;
      s1_in_range  <= 32'(channel) < CHANNELS;
      s1_load.thr  <= COUNT_BITS'(threshold);
      s1_load.cnt  <= COUNT_BITS'(start_count);
      s1_load.cand <= start_level;
      s1_load.stab <= start_stable;
      s1_load.ntf  <= notify_enable;
      rd_data      <= mem[IDX_W'(channel)];
      rd_vld       <= vld[IDX_W'(channel)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(s1_ch)] <= upd;
    end
  end

endmodule

>>> hdl/dbc_queue.sv
module dbc_queue import dbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  evt_t    push_evt,
  input  logic    pop,
  output evt_t    head,
  output q_stat_t stat
);

  evt_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;

  assign head          = q[rp];
  assign stat.count    = count;
  assign stat.nonempty = count != '0;
  // room for the word in flight plus one more
  assign stat.room     = count <= QCNT_W'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_evt;
    end
  end

endmodule

>>> hdl/dbc_back.sv
module dbc_back import dbc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  q_stat_t         stat,
  input  evt_t            head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] event_channel,
  output logic            asserted
);

  assign pop = stat.nonempty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= stat.nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_channel <= head.ch;
      asserted      <= head.asserted;
    end
  end

endmodule

>>> hdl/multi_channel_io_debouncer.sv
// channel  direction  handshake              words
// in       input      in_valid / in_stall    setup or sample, one per cycle
// out      output     out_valid / out_stall  level change events, zero or one per input
// cfg      input      cfg_wr_en              active channel count
//
// one input word per cycle unless stalled; events pass stage s1, the queue, output regs
// per-channel state sits in a 64-entry table, read at accept, written in the next cycle
// with forwarding of that write, so same-channel words can follow back to back
// synchronous reset clears the table's valid bits at once; no clearing sweep
// in_stall rises while the event queue has fewer than two free entries

module multi_channel_io_debouncer import dbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [CH_W-1:0]    channel,
  input  logic               level,
  input  logic [FIELD_W-1:0] threshold,
  input  logic               start_level,
  input  logic               start_stable,
  input  logic [FIELD_W-1:0] start_count,
  input  logic               notify_enable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    event_channel,
  output logic               asserted,
  input  logic               cfg_wr_en,
  input  logic [ACT_W-1:0]   cfg_wr_data
);

  logic [ACT_W-1:0] active_channels;
  logic             accept;
  logic             push;
  evt_t             push_evt;
  logic             s1_setup;
  logic             pop;
  evt_t             head;
  q_stat_t          q_stat;

  assign in_stall = !q_stat.room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= '0;
    end else if (cfg_wr_en) begin
      active_channels <= cfg_wr_data;
    end
  end

  dbc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .func            (func),
    .channel         (channel),
    .level           (level),
    .threshold       (threshold),
    .start_level     (start_level),
    .start_stable    (start_stable),
    .start_count     (start_count),
    .notify_enable   (notify_enable),
    .active_channels (active_channels),
    .push            (push),
    .push_evt        (push_evt),
    .s1_setup        (s1_setup)
  );

  dbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  dbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .stat          (q_stat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_channel (event_channel),
    .asserted      (asserted)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_stat.count != QCNT_W'(QUEUE_DEPTH))
    else $error("event queue overflow");

  a_setup_silent: assert property (@(posedge clk) disable iff (rst)
    s1_setup |-> !push)
    else $error("setup word raised an event");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && q_stat.count == '0)
    else $error("output or queue not empty after reset");
`endif

endmodule
